// File: hdl/memory_map_line_parser_macros.svh
// Assertion macros for the memory-map line parser checks.
// No dependencies; included by the checker file.
`ifndef MEMORY_MAP_LINE_PARSER_MACROS_SVH
`define MEMORY_MAP_LINE_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MMLP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MMLP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mmlp_pkg.sv
// Shared types, character codes and helper functions for the memory-map
// line parser. No dependencies.
`timescale 1ns / 1ps

package mmlp_pkg;

    localparam int MAX_LINE_DEF = 4096;
    localparam int COL_W        = 12;   // width of column fields on the result bus

    // character codes
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_SYNTAX = 1'b1;

    typedef enum logic [3:0] {
        PH_START,
        PH_END,
        PH_PERM_R,
        PH_PERM_W,
        PH_PERM_X,
        PH_PERM_P,
        PH_SPACE2,
        PH_OFFSET,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] start_accum;
        logic [31:0] end_accum;
        logic [31:0] offset_accum;
        logic        digit_seen;
        logic [2:0]  perm_bits;    // r, w, x from high bit down
        logic        token_slash;
    } t_line_state;

    localparam t_line_state LINE_CLEAR = '{
        phase:        PH_START,
        start_accum:  32'h0,
        end_accum:    32'h0,
        offset_accum: 32'h0,
        digit_seen:   1'b0,
        perm_bits:    3'b000,
        token_slash:  1'b0
    };

    typedef struct packed {
        logic [31:0]      start_addr;
        logic [31:0]      region_size;
        logic             can_read;
        logic             can_write;
        logic             can_execute;
        logic [31:0]      file_offset;
        logic             has_file;
        logic [COL_W-1:0] name_column;
        logic [COL_W-1:0] name_length;
        logic             status;
        logic [COL_W-1:0] error_column;
    } t_record;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
    endfunction

    // nibble value; only meaningful when is_hex() holds
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
        end else if (c inside {[8'h61:8'h66]}) begin
            v = c - 8'h57;
        end else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

endpackage

// File: hdl/mmlp_parse.sv
// One-byte step of the line parser: next line state and the record, if any.
// Purely combinational; depends on mmlp_pkg.
`timescale 1ns / 1ps

module mmlp_parse #(
    parameter  int MAX_LINE = mmlp_pkg::MAX_LINE_DEF,
    localparam int CW       = $clog2(MAX_LINE)
) (
    input  mmlp_pkg::t_line_state i_state,
    input  logic [CW-1:0]         i_line_column,
    input  logic [CW-1:0]         i_token_start,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_last_byte,
    output mmlp_pkg::t_line_state o_state,
    output logic [CW-1:0]         o_line_column,
    output logic [CW-1:0]         o_token_start,
    output logic                  o_emit,
    output mmlp_pkg::t_record     o_record
);
    import mmlp_pkg::*;

    localparam logic [CW-1:0] COL_LAST  = CW'(MAX_LINE - 1);
    localparam logic [CW:0]   COL_LIMIT = (CW+1)'(MAX_LINE - 1);

    logic          w_is_nl;
    logic          w_white;
    logic          w_hex;
    logic [3:0]    w_hval;
    logic [CW:0]   w_col_p1;
    logic [CW-1:0] w_col_inc;
    t_phase        n_phase;
    logic          w_bad;
    t_line_state   w_upd;
    logic [CW-1:0] w_tok_upd;
    logic          w_done_before;
    logic          w_done_after;

    // record sources
    t_line_state   w_src_state;
    logic [CW-1:0] w_src_tok;
    logic [CW-1:0] w_src_eol;
    logic          w_make_err;
    logic [CW-1:0] w_err_col;
    logic          w_file;
    logic [CW-1:0] w_name_len;

    assign w_is_nl   = (i_text_byte == CH_NL);
    assign w_white   = is_white(i_text_byte);
    assign w_hex     = is_hex(i_text_byte);
    assign w_hval    = hex_val(i_text_byte);
    assign w_col_p1  = {1'b0, i_line_column} + {{CW{1'b0}}, 1'b1};
    assign w_col_inc = (w_col_p1 > COL_LIMIT) ? COL_LAST : w_col_p1[CW-1:0];

    // pattern phase and violation check
    always_comb begin
        n_phase = i_state.phase;
        w_bad   = 1'b0;
        case (i_state.phase)
            PH_START: begin
                if (!w_hex) begin
                    if (i_state.digit_seen && i_text_byte == CH_DASH) begin
                        n_phase = PH_END;
                    end else begin
                        w_bad = 1'b1;
                    end
                end
            end
            PH_END: begin
                if (!w_hex) begin
                    if (i_state.digit_seen && i_text_byte == CH_SPACE) begin
                        n_phase = PH_PERM_R;
                    end else begin
                        w_bad = 1'b1;
                    end
                end
            end
            PH_PERM_R: begin
                n_phase = PH_PERM_W;
                w_bad   = !(i_text_byte inside {CH_R, CH_DASH});
            end
            PH_PERM_W: begin
                n_phase = PH_PERM_X;
                w_bad   = !(i_text_byte inside {CH_W, CH_DASH});
            end
            PH_PERM_X: begin
                n_phase = PH_PERM_P;
                w_bad   = !(i_text_byte inside {CH_X, CH_DASH});
            end
            PH_PERM_P: begin
                n_phase = PH_SPACE2;
                w_bad   = !(i_text_byte inside {CH_P, CH_S, CH_DASH});
            end
            PH_SPACE2: begin
                n_phase = PH_OFFSET;
                w_bad   = (i_text_byte != CH_SPACE);
            end
            PH_OFFSET: begin
                if (!w_hex) begin
                    if (i_state.digit_seen) begin
                        n_phase = PH_SKIP;
                    end else begin
                        w_bad = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = PH_SKIP;
            end
        endcase
    end

    // accumulators, permissions, token tracking
    always_comb begin
        w_upd       = i_state;
        w_upd.phase = n_phase;
        case (i_state.phase)
            PH_START: begin
                if (w_hex) begin
                    w_upd.start_accum = {i_state.start_accum[27:0], w_hval};
                    w_upd.digit_seen  = 1'b1;
                end else begin
                    w_upd.digit_seen  = 1'b0;
                end
            end
            PH_END: begin
                if (w_hex) begin
                    w_upd.end_accum  = {i_state.end_accum[27:0], w_hval};
                    w_upd.digit_seen = 1'b1;
                end else begin
                    w_upd.digit_seen = 1'b0;
                end
            end
            PH_PERM_R: begin
                if (i_text_byte == CH_R) w_upd.perm_bits[2] = 1'b1;
            end
            PH_PERM_W: begin
                if (i_text_byte == CH_W) w_upd.perm_bits[1] = 1'b1;
            end
            PH_PERM_X: begin
                if (i_text_byte == CH_X) w_upd.perm_bits[0] = 1'b1;
            end
            PH_SPACE2: begin
                w_upd.digit_seen = 1'b0;
            end
            PH_OFFSET: begin
                if (w_hex) begin
                    w_upd.offset_accum = {i_state.offset_accum[27:0], w_hval};
                    w_upd.digit_seen   = 1'b1;
                end
            end
            default: begin
            end
        endcase

        w_tok_upd = i_token_start;
        if (w_white) begin
            w_tok_upd         = w_col_inc;
            w_upd.token_slash = 1'b0;
        end else if (i_line_column == i_token_start) begin
            w_upd.token_slash = (i_text_byte == CH_SLASH);
        end
    end

    assign w_done_before = (i_state.phase == PH_SKIP) ||
                           (i_state.phase == PH_OFFSET && i_state.digit_seen);
    assign w_done_after  = (w_upd.phase == PH_SKIP) ||
                           (w_upd.phase == PH_OFFSET && w_upd.digit_seen);

    // outcome of this byte
    always_comb begin
        o_state       = w_upd;
        o_line_column = w_col_inc;
        o_token_start = w_tok_upd;
        o_emit        = 1'b0;
        w_src_state   = w_upd;
        w_src_tok     = w_tok_upd;
        w_src_eol     = w_col_inc;
        w_make_err    = 1'b0;
        w_err_col     = i_line_column;
        if (w_is_nl) begin
            // newline: token state is left as the line had it
            o_emit        = 1'b1;
            o_state       = LINE_CLEAR;
            o_line_column = '0;
            o_token_start = '0;
            w_src_state   = i_state;
            w_src_tok     = i_token_start;
            w_src_eol     = i_line_column;
            w_make_err    = !w_done_before;
        end else if (w_bad) begin
            o_emit     = 1'b1;
            w_make_err = 1'b1;
        end else if (i_last_byte) begin
            // end of text: line closes one column after this byte
            o_emit        = 1'b1;
            o_state       = LINE_CLEAR;
            o_line_column = '0;
            o_token_start = '0;
            w_make_err    = !w_done_after;
            w_err_col     = w_col_inc;
        end
    end

    assign w_file     = w_src_state.token_slash &&
                        (({1'b0, w_src_tok} + {{CW{1'b0}}, 1'b1}) < {1'b0, w_src_eol});
    assign w_name_len = w_src_eol - w_src_tok;

    always_comb begin
        o_record = '0;
        if (w_make_err) begin
            o_record.status       = STATUS_SYNTAX;
            o_record.error_column = COL_W'(w_err_col);
        end else begin
            o_record.status      = STATUS_OK;
            o_record.start_addr  = w_src_state.start_accum;
            o_record.region_size = w_src_state.end_accum - w_src_state.start_accum;
            o_record.can_read    = w_src_state.perm_bits[2];
            o_record.can_write   = w_src_state.perm_bits[1];
            o_record.can_execute = w_src_state.perm_bits[0];
            if (w_file) begin
                o_record.file_offset = w_src_state.offset_accum;
                o_record.has_file    = 1'b1;
                o_record.name_column = COL_W'(w_src_tok);
                o_record.name_length = COL_W'(w_name_len);
            end
        end
    end

endmodule

// File: hdl/memory_map_line_parser.sv
// Top level of the memory-map line parser: stream ports, line state
// registers and the result register. Depends on mmlp_pkg and mmlp_parse.
`timescale 1ns / 1ps

// Parses memory-map text, one byte per request on the slave stream, with
// tlast marking the final byte of the text. Each line must read
// "start-end perms offset ..."; at a newline or at the final byte one record
// goes out on the master stream: start, size (end - start mod 2^32), r/w/x
// flags and, when the last token of the line is a path ("/" and at least two
// bytes), its offset, column and length. tuser is 1 for a syntax-error record,
// which carries only the error column; after it the block drops all further
// bytes without output until reset. Rate: one byte per clock, sustained; the
// whole line-state update is one pass of logic into the state registers, and
// a record appears in the cycle after the byte that closes the line. tready
// drops only while a record sits in the output register and the master side
// stalls. Columns saturate at MAX_LINE-1 and show as 12 bits on the bus.
module memory_map_line_parser #(
    parameter  int MAX_LINE = mmlp_pkg::MAX_LINE_DEF,
    localparam int CW       = $clog2(MAX_LINE)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side: text bytes
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] text_byte
    input  logic         i_s_axis_tlast,   // last_byte
    // master side: line records
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] start_addr, [63:32] region_size, [64] can_read, [65] can_write,
    // [66] can_execute, [98:67] file_offset, [99] has_file,
    // [111:100] name_column, [123:112] name_length, [135:124] error_column
    output logic [135:0] o_m_axis_tdata,
    output logic         o_m_axis_tuser    // status
);
    import mmlp_pkg::*;

    t_line_state   r_state;
    logic [CW-1:0] r_line_column;
    logic [CW-1:0] r_token_start;
    logic          r_error_latched;
    logic          r_out_valid;
    t_record       r_out;

    t_line_state   n_state;
    logic [CW-1:0] n_line_column;
    logic [CW-1:0] n_token_start;
    logic          n_emit;
    t_record       n_record;

    logic          w_in_accept;
    logic          w_step;

    mmlp_parse #(
        .MAX_LINE (MAX_LINE)
    ) u_parse (
        .i_state       (r_state),
        .i_line_column (r_line_column),
        .i_token_start (r_token_start),
        .i_text_byte   (i_s_axis_tdata),
        .i_last_byte   (i_s_axis_tlast),
        .o_state       (n_state),
        .o_line_column (n_line_column),
        .o_token_start (n_token_start),
        .o_emit        (n_emit),
        .o_record      (n_record)
    );

    // output register frees up in the same cycle it is drained
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;
    // once an error went out, bytes are taken and dropped
    assign w_step          = w_in_accept && !r_error_latched;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= LINE_CLEAR;
            r_line_column   <= '0;
            r_token_start   <= '0;
            r_error_latched <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (w_step) begin
                r_state       <= n_state;
                r_line_column <= n_line_column;
                r_token_start <= n_token_start;
                if (n_emit && n_record.status == STATUS_SYNTAX) begin
                    r_error_latched <= 1'b1;
                end
            end
            if (w_step && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_step && n_emit) begin
            r_out <= n_record;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {r_out.error_column, r_out.name_length, r_out.name_column,
                              r_out.has_file, r_out.file_offset, r_out.can_execute,
                              r_out.can_write, r_out.can_read, r_out.region_size,
                              r_out.start_addr};

endmodule

// File: hdl/mmlp_checker.sv
// Port-level checks for the memory-map line parser, bound to the top level.
// Depends on memory_map_line_parser_macros.svh.
`timescale 1ns / 1ps
`include "memory_map_line_parser_macros.svh"

module mmlp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [7:0]   i_s_axis_tdata,
    input logic         i_s_axis_tlast,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [135:0] o_m_axis_tdata,
    input logic         o_m_axis_tuser
);
    logic w_in_req;
    logic w_err_done;
    logic r_err_seen;

    assign w_in_req   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_err_done = o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tuser;

    // set once an error record has been taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_seen <= 1'b0;
        end else if (w_err_done) begin
            r_err_seen <= 1'b1;
        end
    end

    `MMLP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled record changed or dropped")
    `MMLP_ASSERT_IMP(a_silent_after_err, i_clk, i_rst_n, r_err_seen, !o_m_axis_tvalid, "record after syntax error")
    `MMLP_ASSERT_IMP(a_err_fields_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata[123:0] == 124'h0, "error record carries data")
    `MMLP_ASSERT_IMP(a_nofile_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser && !o_m_axis_tdata[99], o_m_axis_tdata[98:67] == 32'h0 && o_m_axis_tdata[135:100] == 36'h0, "record without file has offset or name data")
    `MMLP_ASSERT_IMP(a_out_from_req, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(w_in_req), "record without an input request")

endmodule

bind memory_map_line_parser mmlp_checker u_mmlp_checker (.*);
